[sv/pip_pkg.sv]
// ----------------------------------------------------------------------------
// Point-in-polygon test package
// Shared types and constants for the ray-casting edge chain.
// ----------------------------------------------------------------------------
package pip_pkg;

    // Width of the vertex count register and its value after reset.
    localparam int unsigned CNT_W = 7;
    localparam logic [CNT_W-1:0] CNT_RESET = 7'd3;

    // Width of the vertex slot field of a write beat.
    localparam int unsigned IDX_W = 6;

    // Width used to compare counts and slot numbers against cell positions.
    localparam int unsigned CMP_W = 11;

    // Request codes.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Per-cell control from the top level.
    typedef struct packed {
        logic wr_en;   // load this cell's vertex
        logic active;  // the cell's edge is part of the polygon
        logic last;    // the cell's edge closes back to vertex zero
    } t_cell_ctrl;

endpackage

[sv/pip_edge_cell.sv]
// ----------------------------------------------------------------------------
// Point-in-polygon edge cell
// Holds one vertex, forms the edge to its neighbor and tests a passing query
// point against it in two pipeline stages, toggling the running parity.
// ----------------------------------------------------------------------------
module pip_edge_cell #(
    parameter int unsigned COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pip_pkg::t_cell_ctrl           i_ctrl,
    input  logic signed [COORD_WIDTH-1:0] i_wr_x,
    input  logic signed [COORD_WIDTH-1:0] i_wr_y,
    input  logic signed [COORD_WIDTH-1:0] i_next_x,
    input  logic signed [COORD_WIDTH-1:0] i_next_y,
    input  logic signed [COORD_WIDTH-1:0] i_first_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_y,
    input  logic                          i_valid,
    input  logic                          i_par,
    input  logic signed [COORD_WIDTH-1:0] i_x,
    input  logic signed [COORD_WIDTH-1:0] i_y,
    output logic signed [COORD_WIDTH-1:0] o_vx,
    output logic signed [COORD_WIDTH-1:0] o_vy,
    output logic                          o_valid,
    output logic                          o_par,
    output logic signed [COORD_WIDTH-1:0] o_x,
    output logic signed [COORD_WIDTH-1:0] o_y
);

    localparam int unsigned DW = COORD_WIDTH + 1;
    localparam int unsigned PW = 2 * DW;

    // Stored vertex.
    logic signed [COORD_WIDTH-1:0] r_vx, r_vy;

    // Stage one: oriented differences and edge flags.
    logic                          r1_valid, n1_valid;
    logic                          r1_par;
    logic signed [COORD_WIDTH-1:0] r1_x, r1_y;
    logic                          r1_cond, n1_cond;
    logic                          r1_vert, n1_vert;
    logic signed [DW-1:0]          r1_d1, r1_d2, r1_d3, r1_d4;
    logic signed [DW-1:0]          n1_d1, n1_d2, n1_d3, n1_d4;

    // Stage two: cross products.
    logic                          r2_valid;
    logic                          r2_par;
    logic signed [COORD_WIDTH-1:0] r2_x, r2_y;
    logic                          r2_cond, r2_vert;
    logic signed [PW-1:0]          r2_p1, r2_p2, n2_p1, n2_p2;

    logic signed [COORD_WIDTH-1:0] bx, by, xa, ya, xb, yb, maxx;
    logic signed [DW-1:0]          ex_px, ex_py, ex_xa, ex_ya, ex_xb, ex_yb;

    always_comb begin
        bx = i_ctrl.last ? i_first_x : i_next_x;
        by = i_ctrl.last ? i_first_y : i_next_y;
        // Orient the edge so that it runs upward from a to b.
        if (r_vy > by) begin
            xa = bx;
            ya = by;
            xb = r_vx;
            yb = r_vy;
        end else begin
            xa = r_vx;
            ya = r_vy;
            xb = bx;
            yb = by;
        end
        maxx  = (r_vx > bx) ? r_vx : bx;
        ex_px = {i_x[COORD_WIDTH-1], i_x};
        ex_py = {i_y[COORD_WIDTH-1], i_y};
        ex_xa = {xa[COORD_WIDTH-1], xa};
        ex_ya = {ya[COORD_WIDTH-1], ya};
        ex_xb = {xb[COORD_WIDTH-1], xb};
        ex_yb = {yb[COORD_WIDTH-1], yb};
        n1_valid = i_valid;
        n1_cond  = i_ctrl.active && (r_vy != by) && (i_y > ya) && (i_y <= yb)
                   && (i_x <= maxx);
        n1_vert  = (r_vx == bx);
        n1_d1    = ex_px - ex_xa;
        n1_d2    = ex_yb - ex_ya;
        n1_d3    = ex_py - ex_ya;
        n1_d4    = ex_xb - ex_xa;
    end

    // The point is left of the edge when (px-xa)*dy <= (py-ya)*dx.
    always_comb begin
        n2_p1 = PW'(r1_d1) * PW'(r1_d2);
        n2_p2 = PW'(r1_d3) * PW'(r1_d4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= n1_valid;
            r2_valid <= r1_valid;
        end
        if (i_ctrl.wr_en) begin
            r_vx <= i_wr_x;
            r_vy <= i_wr_y;
        end
        r1_par  <= i_par;
        r1_x    <= i_x;
        r1_y    <= i_y;
        r1_cond <= n1_cond;
        r1_vert <= n1_vert;
        r1_d1   <= n1_d1;
        r1_d2   <= n1_d2;
        r1_d3   <= n1_d3;
        r1_d4   <= n1_d4;
        r2_par  <= r1_par;
        r2_x    <= r1_x;
        r2_y    <= r1_y;
        r2_cond <= r1_cond;
        r2_vert <= r1_vert;
        r2_p1   <= n2_p1;
        r2_p2   <= n2_p2;
    end

    assign o_vx    = r_vx;
    assign o_vy    = r_vy;
    assign o_valid = r2_valid;
    assign o_par   = r2_par ^ (r2_cond & (r2_vert | (r2_p1 <= r2_p2)));
    assign o_x     = r2_x;
    assign o_y     = r2_y;

endmodule

[sv/point_in_polygon_test_core.sv]
// ----------------------------------------------------------------------------
// Point-in-polygon test core
// Even-odd ray casting over a polygon held in a chain of edge cells.
// ----------------------------------------------------------------------------
// A vertex write beat takes effect at the edge that accepts it and gives no
// result. A query beat enters the cell chain and may be followed by another
// query in the very next cycle; its result appears on o_inside_res with the
// o_valid strobe once it has passed the two pipeline stages of each edge
// cell and then the output register. The receiver cannot stall, so results
// must be taken in the cycle they are shown. A vertex write beat is held off
// with o_busy while any query is still in the chain, so queries always see the
// vertices as they stood when accepted; i_cfg_we writes are not held off.
// ----------------------------------------------------------------------------
module point_in_polygon_test_core #(
    parameter int unsigned MAX_VERTICES = 64,
    parameter int unsigned COORD_WIDTH  = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pip_pkg::CNT_W-1:0]      i_cfg_wdata,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_req_type,
    input  logic [pip_pkg::IDX_W-1:0]      i_vertex_index,
    input  logic signed [COORD_WIDTH-1:0]  i_coord_x,
    input  logic signed [COORD_WIDTH-1:0]  i_coord_y,
    output logic                           o_valid,
    output logic                           o_inside_res
);

    localparam int unsigned LAT   = 2 * MAX_VERTICES + 1;
    localparam int unsigned FLT_W = $clog2(LAT + 1);

    logic [pip_pkg::CNT_W-1:0] r_count;
    logic [FLT_W-1:0]          r_inflight, n_inflight;
    logic                      r_valid, r_inside;
    logic                      accept, q_accept, w_accept;

    logic                          ch_valid [0:MAX_VERTICES];
    logic                          ch_par   [0:MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] ch_x     [0:MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] ch_y     [0:MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] vx       [0:MAX_VERTICES-1];
    logic signed [COORD_WIDTH-1:0] vy       [0:MAX_VERTICES-1];
    pip_pkg::t_cell_ctrl           ctrl     [0:MAX_VERTICES-1];

    assign o_busy   = (r_inflight != '0) && (i_req_type == pip_pkg::REQ_WRITE);
    assign accept   = i_start && !o_busy;
    assign q_accept = accept && (i_req_type == pip_pkg::REQ_QUERY);
    assign w_accept = accept && (i_req_type == pip_pkg::REQ_WRITE);

    assign ch_valid[0] = q_accept;
    assign ch_par[0]   = 1'b0;
    assign ch_x[0]     = i_coord_x;
    assign ch_y[0]     = i_coord_y;

    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        localparam int unsigned NXT = (k + 1 < MAX_VERTICES) ? k + 1 : 0;

        assign ctrl[k].wr_en  = w_accept &&
                                (pip_pkg::CMP_W'(i_vertex_index) == pip_pkg::CMP_W'(k));
        assign ctrl[k].active = pip_pkg::CMP_W'(r_count) > pip_pkg::CMP_W'(k);
        assign ctrl[k].last   = pip_pkg::CMP_W'(r_count) == pip_pkg::CMP_W'(k + 1);

        pip_edge_cell #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (ctrl[k]),
            .i_wr_x    (i_coord_x),
            .i_wr_y    (i_coord_y),
            .i_next_x  (vx[NXT]),
            .i_next_y  (vy[NXT]),
            .i_first_x (vx[0]),
            .i_first_y (vy[0]),
            .i_valid   (ch_valid[k]),
            .i_par     (ch_par[k]),
            .i_x       (ch_x[k]),
            .i_y       (ch_y[k]),
            .o_vx      (vx[k]),
            .o_vy      (vy[k]),
            .o_valid   (ch_valid[k+1]),
            .o_par     (ch_par[k+1]),
            .o_x       (ch_x[k+1]),
            .o_y       (ch_y[k+1])
        );
    end

    // Queries in the chain or the output register.
    always_comb begin
        n_inflight = r_inflight;
        if (q_accept && !r_valid) begin
            n_inflight = r_inflight + FLT_W'(1);
        end else if (!q_accept && r_valid) begin
            n_inflight = r_inflight - FLT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= pip_pkg::CNT_RESET;
            r_inflight <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            r_inflight <= n_inflight;
            r_valid    <= ch_valid[MAX_VERTICES];
        end
        r_inside <= ch_par[MAX_VERTICES];
    end

    assign o_valid      = r_valid;
    assign o_inside_res = r_inside;

endmodule
